/* hdl/owbm_pkg.sv */
package owbm_pkg;

    localparam int CNT_W = 16;

    // configuration register indexes
    localparam logic [2:0] REG_RESET_LOW   = 3'd0;
    localparam logic [2:0] REG_PRES_WINDOW = 3'd1;
    localparam logic [2:0] REG_SHORT_LOW   = 3'd2;
    localparam logic [2:0] REG_W1_WAIT     = 3'd3;
    localparam logic [2:0] REG_W0_LOW      = 3'd4;
    localparam logic [2:0] REG_RD_DELAY    = 3'd5;
    localparam logic [2:0] REG_RD_WAIT     = 3'd6;

    localparam logic [15:0] RST_RESET_LOW   = 16'd2500;
    localparam logic [15:0] RST_PRES_WINDOW = 16'd255;
    localparam logic [7:0]  RST_SHORT_LOW   = 8'd2;
    localparam logic [15:0] RST_W1_WAIT     = 16'd260;
    localparam logic [15:0] RST_W0_LOW      = 16'd275;
    localparam logic [15:0] RST_RD_DELAY    = 16'd1;
    localparam logic [15:0] RST_RD_WAIT     = 16'd140;

    localparam logic [3:0] BYTE_BITS = 4'd8;
    localparam logic [3:0] ONE_BIT   = 4'd1;

    typedef enum logic [1:0] {
        CMD_RESET     = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_READ_BYTE = 2'd2,
        CMD_READ_BIT  = 2'd3
    } cmd_t;

    typedef enum logic [9:0] {
        PH_IDLE     = 10'b00_0000_0001,
        PH_RST_LOW  = 10'b00_0000_0010,
        PH_PRES     = 10'b00_0000_0100,
        PH_W1_LOW   = 10'b00_0000_1000,
        PH_W1_WAIT  = 10'b00_0001_0000,
        PH_W0_LOW   = 10'b00_0010_0000,
        PH_R_LOW    = 10'b00_0100_0000,
        PH_R_DELAY  = 10'b00_1000_0000,
        PH_R_SAMPLE = 10'b01_0000_0000,
        PH_R_WAIT   = 10'b10_0000_0000
    } phase_t;

    // one decoded tick request
    typedef struct packed {
        logic       start;
        cmd_t       act;
        logic [7:0] wdata;
        logic       line;
    } item_t;

endpackage

/* hdl/owbm_front.sv */
module owbm_front
    import owbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    output item_t       head,
    output logic        head_valid,
    input  logic        pop
);

    item_t       q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    item_t       in_item;

    always_comb begin
        in_item.start = s_tuser[0];
        in_item.act   = cmd_t'(s_tuser[2:1]);
        in_item.wdata = s_tdata[7:0];
        in_item.line  = s_tdata[8];
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head       = q_mem[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* hdl/owbm_engine.sv */
module owbm_engine
    import owbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  item_t       head,
    input  logic        head_valid,
    output logic        pop,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata
);

    logic [15:0]      rst_low_reg, pres_win_reg, w1_wait_reg, w0_low_reg;
    logic [15:0]      rd_delay_reg, rd_wait_reg;
    logic [7:0]       short_low_reg;
    // zero-length flags for the write slot phases
    logic             z_short_reg, z_w1_wait_reg, z_w0_low_reg;

    phase_t           phase_reg, ph;
    logic [CNT_W-1:0] cnt_reg, cnt;
    logic [3:0]       bit_idx_reg, bi;
    logic [7:0]       shift_reg, sb;
    logic             pres_reg, pres;
    cmd_t             cmd_reg, cmd;

    logic             fin, slot_req, found, bitv, busy, low;
    logic [2:0]       sel;
    logic [3:0]       nbits;
    logic [7:0]       rd;

    logic             m_valid_reg;
    logic [15:0]      m_data_reg;

    assign cfg_ready = 1'b1;
    assign pop       = head_valid && (!m_valid_reg || m_tready);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rst_low_reg   <= RST_RESET_LOW;
            pres_win_reg  <= RST_PRES_WINDOW;
            short_low_reg <= RST_SHORT_LOW;
            w1_wait_reg   <= RST_W1_WAIT;
            w0_low_reg    <= RST_W0_LOW;
            rd_delay_reg  <= RST_RD_DELAY;
            rd_wait_reg   <= RST_RD_WAIT;
            z_short_reg   <= 1'b0;
            z_w1_wait_reg <= 1'b0;
            z_w0_low_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RESET_LOW:   rst_low_reg  <= cfg_data;
                REG_PRES_WINDOW: pres_win_reg <= cfg_data;
                REG_SHORT_LOW: begin
                    short_low_reg <= cfg_data[7:0];
                    z_short_reg   <= (cfg_data[7:0] == 8'd0);
                end
                REG_W1_WAIT: begin
                    w1_wait_reg   <= cfg_data;
                    z_w1_wait_reg <= (cfg_data == 16'd0);
                end
                REG_W0_LOW: begin
                    w0_low_reg    <= cfg_data;
                    z_w0_low_reg  <= (cfg_data == 16'd0);
                end
                REG_RD_DELAY:    rd_delay_reg <= cfg_data;
                REG_RD_WAIT:     rd_wait_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // One tick: start, then fall through every phase whose count is already zero.
    always_comb begin
        ph       = phase_reg;
        cnt      = cnt_reg;
        bi       = bit_idx_reg;
        sb       = shift_reg;
        pres     = pres_reg;
        cmd      = cmd_reg;
        fin      = 1'b0;
        slot_req = 1'b0;
        found    = 1'b0;
        sel      = 3'd0;
        bitv     = 1'b0;
        busy     = 1'b0;
        low      = 1'b0;

        if (ph == PH_IDLE && head.start) begin
            cmd = head.act;
            bi  = 4'd0;
            if (head.act == CMD_RESET) begin
                sb   = 8'd0;
                pres = 1'b0;
                ph   = PH_RST_LOW;
                cnt  = rst_low_reg;
            end else begin
                sb       = (head.act == CMD_WRITE) ? head.wdata : 8'd0;
                slot_req = 1'b1;
            end
        end

        nbits = (cmd == CMD_READ_BIT) ? ONE_BIT : BYTE_BITS;

        if (ph == PH_RST_LOW && cnt == '0) begin
            ph  = PH_PRES;
            cnt = pres_win_reg;
        end
        if (ph == PH_PRES && cnt == '0) begin
            ph  = PH_IDLE;
            fin = 1'b1;
        end
        if (ph == PH_R_SAMPLE && cnt == '0) begin
            ph  = PH_R_WAIT;
            cnt = rd_wait_reg;
        end
        if (ph == PH_W1_LOW && cnt == '0) begin
            ph  = PH_W1_WAIT;
            cnt = w1_wait_reg;
        end
        if ((ph == PH_R_WAIT || ph == PH_W1_WAIT || ph == PH_W0_LOW) && cnt == '0) begin
            bi = bi + 4'd1;
            if (bi >= nbits) begin
                ph  = PH_IDLE;
                fin = 1'b1;
            end else begin
                slot_req = 1'b1;
            end
        end

        if (slot_req) begin
            if (cmd == CMD_WRITE) begin
                // first remaining bit whose slot is not entirely zero length
                for (int j = 7; j >= 0; j--) begin
                    if (({1'b0, bi} + 5'(j)) < 5'd8 &&
                        !(sb[j] ? (z_short_reg && z_w1_wait_reg) : z_w0_low_reg)) begin
                        found = 1'b1;
                        sel   = 3'(j);
                    end
                end
                if (!found) begin
                    ph  = PH_IDLE;
                    fin = 1'b1;
                    bi  = BYTE_BITS;
                    sb  = 8'd0;
                end else begin
                    bi   = bi + {1'b0, sel};
                    bitv = sb[sel];
                    sb   = sb >> ({1'b0, sel} + 4'd1);
                    if (bitv) begin
                        if (z_short_reg) begin
                            ph  = PH_W1_WAIT;
                            cnt = w1_wait_reg;
                        end else begin
                            ph  = PH_W1_LOW;
                            cnt = {8'd0, short_low_reg};
                        end
                    end else begin
                        ph  = PH_W0_LOW;
                        cnt = w0_low_reg;
                    end
                end
            end else begin
                ph  = PH_R_LOW;
                cnt = {8'd0, short_low_reg};
            end
        end

        if (ph == PH_R_LOW && cnt == '0) begin
            ph  = PH_R_DELAY;
            cnt = rd_delay_reg;
        end
        if (ph == PH_R_DELAY && cnt == '0) begin
            ph  = PH_R_SAMPLE;
            cnt = CNT_W'(1);
        end

        if (fin) begin
            cnt = '0;
        end else if (ph != PH_IDLE) begin
            busy = 1'b1;
            low  = (ph == PH_RST_LOW) || (ph == PH_W1_LOW) ||
                   (ph == PH_W0_LOW) || (ph == PH_R_LOW);
            if (ph == PH_PRES && !head.line) begin
                pres = 1'b1;
            end
            if (ph == PH_R_SAMPLE) begin
                sb = (cmd == CMD_READ_BIT) ? {7'd0, head.line} : {head.line, sb[7:1]};
            end
            if (cnt != '0) begin
                cnt = cnt - CNT_W'(1);
            end
        end

        rd = (!busy && (cmd == CMD_READ_BYTE || cmd == CMD_READ_BIT)) ? sb : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            bit_idx_reg <= 4'd0;
            shift_reg   <= 8'd0;
            pres_reg    <= 1'b0;
            cmd_reg     <= CMD_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg   <= ph;
                cnt_reg     <= cnt;
                bit_idx_reg <= bi;
                shift_reg   <= sb;
                pres_reg    <= pres;
                cmd_reg     <= cmd;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= {4'd0, pres, rd, fin, busy, low};
        end
    end

endmodule

/* hdl/one_wire_bus_master_unit.sv */
// 1-Wire slot engine: one tick request in, one line/status result out.
// A request is registered in the queue, then its result in the output register on the m_ side;
// a stalled m_ side holds requests in the queue.
// Throughput: one request per cycle while the m_ side takes results; the engine resolves
// each tick, including any chain of zero-length phases, combinationally.
// Reset (aresetn low, synchronous): queue emptied, engine idle, registers to defaults.
module one_wire_bus_master_unit
    import owbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // write_data[7:0], line_in[8], zero pad
    input  logic [2:0]  s_tuser,   // start_req[0], action[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // line_low[0], busy_res[1], done_res[2],
                                   // read_data[10:3], presence[11], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    item_t head;
    logic  head_valid;
    logic  pop;

    owbm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    owbm_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import owbm_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          IDLE_PCT       = 17;
    localparam int          MAX_REPORTS    = 40;
    localparam int          RANDOM_SETS    = 3;
    localparam int          TICKS_PER_SET  = 40;
    localparam logic [2:0]  REG_UNUSED     = 3'd7;

    // engine phases as tracked by the slot predictor; FINISH is the one-tick done state
    typedef enum logic [3:0] {
        ST_IDLE, ST_RST_LOW, ST_PRES, ST_W1_LOW, ST_W1_WAIT, ST_W0_LOW,
        ST_R_LOW, ST_R_DELAY, ST_R_SAMPLE, ST_R_WAIT, ST_FINISH
    } slot_phase_e;

    typedef enum int {LINE_RANDOM, LINE_HIGH, LINE_LOW} line_mode_e;

    // same bit layout as m_tdata
    typedef struct packed {
        logic [3:0] pad;
        logic       presence;
        logic [7:0] read_data;
        logic       done;
        logic       busy;
        logic       line_low;
    } bus_status_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    one_wire_bus_master_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // timing registers as the predictor sees them
    logic [15:0] t_rst_low  = RST_RESET_LOW;
    logic [15:0] t_pres     = RST_PRES_WINDOW;
    logic [7:0]  t_short    = RST_SHORT_LOW;
    logic [15:0] t_w1_wait  = RST_W1_WAIT;
    logic [15:0] t_w0_low   = RST_W0_LOW;
    logic [15:0] t_rd_delay = RST_RD_DELAY;
    logic [15:0] t_rd_wait  = RST_RD_WAIT;

    // predicted engine state
    slot_phase_e eng_ph    = ST_IDLE;
    logic [15:0] eng_ticks = '0;
    logic [3:0]  eng_bit   = '0;
    logic [7:0]  eng_shift = '0;
    logic        eng_pres  = 1'b0;
    cmd_t        eng_cmd   = CMD_RESET;

    bus_status_t status_q [$];
    bit          calm         = 1'b0;
    line_mode_e  line_mode    = LINE_RANDOM;
    int          mismatch_cnt = 0;
    int          results_seen = 0;
    int          ticks_sent   = 0;
    int          idle_cycles  = 0;
    int          cmds_started [4];

    function automatic void enter_phase(slot_phase_e p, logic [15:0] n);
        eng_ph    = p;
        eng_ticks = n;
    endfunction

    function automatic void open_slot();
        logic b;
        if (eng_cmd == CMD_WRITE) begin
            b         = eng_shift[0];
            eng_shift = eng_shift >> 1;
            if (b)
                enter_phase(ST_W1_LOW, {8'd0, t_short});
            else
                enter_phase(ST_W0_LOW, t_w0_low);
        end else begin
            enter_phase(ST_R_LOW, {8'd0, t_short});
        end
    endfunction

    function automatic void finish_bit();
        logic [3:0] nbits;
        nbits   = (eng_cmd == CMD_READ_BIT) ? ONE_BIT : BYTE_BITS;
        eng_bit = eng_bit + 4'd1;
        if (eng_bit >= nbits)
            enter_phase(ST_FINISH, 16'd0);
        else
            open_slot();
    endfunction

    function automatic void advance_phase();
        case (eng_ph)
            ST_RST_LOW:  enter_phase(ST_PRES, t_pres);
            ST_PRES:     enter_phase(ST_FINISH, 16'd0);
            ST_W1_LOW:   enter_phase(ST_W1_WAIT, t_w1_wait);
            ST_R_LOW:    enter_phase(ST_R_DELAY, t_rd_delay);
            ST_R_DELAY:  enter_phase(ST_R_SAMPLE, 16'd1);
            ST_R_SAMPLE: enter_phase(ST_R_WAIT, t_rd_wait);
            ST_W1_WAIT, ST_W0_LOW, ST_R_WAIT: finish_bit();
            default:     enter_phase(ST_FINISH, 16'd0);
        endcase
    endfunction

    // one timer tick through the slot engine
    function automatic bus_status_t step_engine(logic start, cmd_t act, logic [7:0] wdata,
                                                logic line);
        bus_status_t r;
        int          guard;
        r = '0;
        if (eng_ph == ST_IDLE && start) begin
            eng_cmd = act;
            eng_bit = 4'd0;
            cmds_started[act]++;
            if (act == CMD_RESET) begin
                eng_shift = 8'h00;
                eng_pres  = 1'b0;
                enter_phase(ST_RST_LOW, t_rst_low);
            end else begin
                eng_shift = (act == CMD_WRITE) ? wdata : 8'h00;
                open_slot();
            end
        end
        // zero-length phases collapse within the tick
        for (guard = 0; guard < 64; guard++) begin
            if (eng_ph == ST_IDLE || eng_ph == ST_FINISH || eng_ticks != 16'd0)
                break;
            advance_phase();
        end
        if (eng_ph == ST_FINISH) begin
            r.done    = 1'b1;
            eng_ph    = ST_IDLE;
            eng_ticks = 16'd0;
        end else if (eng_ph != ST_IDLE) begin
            r.busy     = 1'b1;
            r.line_low = (eng_ph == ST_RST_LOW || eng_ph == ST_W1_LOW ||
                          eng_ph == ST_W0_LOW || eng_ph == ST_R_LOW);
            if (eng_ph == ST_PRES && !line)
                eng_pres = 1'b1;
            if (eng_ph == ST_R_SAMPLE) begin
                if (eng_cmd == CMD_READ_BIT)
                    eng_shift = {7'd0, line};
                else
                    eng_shift = {line, eng_shift[7:1]};
            end
            if (eng_ticks != 16'd0)
                eng_ticks = eng_ticks - 16'd1;
        end
        if (!r.busy && (eng_cmd == CMD_READ_BYTE || eng_cmd == CMD_READ_BIT))
            r.read_data = eng_shift;
        r.presence = eng_pres;
        return r;
    endfunction

    function automatic logic pick_line();
        case (line_mode)
            LINE_HIGH: return 1'b1;
            LINE_LOW:  return 1'b0;
            default:   return 1'($urandom_range(1));
        endcase
    endfunction

    // one tick request; leaves s_tvalid high for a back-to-back follow-up
    task automatic send_tick(input logic start, input cmd_t act, input logic [7:0] wdata);
        logic line;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        line = pick_line();
        s_tvalid <= 1'b1;
        s_tuser  <= {act, start};
        s_tdata  <= {7'd0, line, wdata};
        do @(posedge aclk); while (!s_tready);
        status_q.push_back(step_engine(start, act, wdata, line));
        ticks_sent++;
    endtask

    // start a command and tick until the engine is back to idle
    task automatic run_cmd(input cmd_t act, input logic [7:0] wdata, input bit noisy);
        send_tick(1'b1, act, wdata);
        while (eng_ph != ST_IDLE)
            send_tick(noisy ? 1'($urandom_range(1)) : 1'b0,
                      cmd_t'($urandom_range(3)), 8'($urandom));
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // leaves cfg_valid high; close_config lowers it
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_RESET_LOW:   t_rst_low  = val;
            REG_PRES_WINDOW: t_pres     = val;
            REG_SHORT_LOW:   t_short    = val[7:0];
            REG_W1_WAIT:     t_w1_wait  = val;
            REG_W0_LOW:      t_w0_low   = val;
            REG_RD_DELAY:    t_rd_delay = val;
            REG_RD_WAIT:     t_rd_wait  = val;
            default: ;
        endcase
    endtask

    task automatic close_config();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_timing(input logic [15:0] rst_low, input logic [15:0] pres,
                               input logic [7:0] short_low, input logic [15:0] w1_wait,
                               input logic [15:0] w0_low, input logic [15:0] rd_delay,
                               input logic [15:0] rd_wait);
        quiesce();
        write_reg(REG_RESET_LOW, rst_low);
        write_reg(REG_PRES_WINDOW, pres);
        write_reg(REG_SHORT_LOW, {8'd0, short_low});
        write_reg(REG_W1_WAIT, w1_wait);
        write_reg(REG_W0_LOW, w0_low);
        write_reg(REG_RD_DELAY, rd_delay);
        write_reg(REG_RD_WAIT, rd_wait);
        close_config();
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        bus_status_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (status_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            end else begin
                want = status_q.pop_front();
                check_field("line_low", 16'(want.line_low), 16'(got.line_low));
                check_field("busy", 16'(want.busy), 16'(got.busy));
                check_field("done", 16'(want.done), 16'(got.done));
                check_field("read_data", 16'(want.read_data), 16'(got.read_data));
                check_field("presence", 16'(want.presence), 16'(got.presence));
                check_field("pad", 16'(want.pad), 16'(got.pad));
            end
        end
    end

    always @(posedge aclk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // default short low, sample delay and slot wait through one read slot
    task automatic test_default_timing();
        line_mode = LINE_RANDOM;
        run_cmd(CMD_READ_BIT, 8'h00, 1'b0);
    endtask

    task automatic test_presence();
        load_timing(16'd3, 16'd4, 8'd1, 16'd1, 16'd1, 16'd0, 16'd1);
        line_mode = LINE_HIGH;
        run_cmd(CMD_RESET, 8'h00, 1'b0);
        line_mode = LINE_LOW;
        run_cmd(CMD_RESET, 8'h00, 1'b0);
        // presence must survive other commands
        line_mode = LINE_HIGH;
        run_cmd(CMD_WRITE, 8'h3C, 1'b0);
        line_mode = LINE_LOW;
        run_cmd(CMD_READ_BIT, 8'h00, 1'b0);
        line_mode = LINE_HIGH;
        run_cmd(CMD_READ_BYTE, 8'h00, 1'b0);
        run_cmd(CMD_RESET, 8'h00, 1'b0);
        line_mode = LINE_RANDOM;
    endtask

    task automatic test_zero_durations();
        load_timing(16'd0, 16'd1, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        // all-zero byte with zero write-zero time: done on the start tick
        run_cmd(CMD_WRITE, 8'h00, 1'b0);
        run_cmd(CMD_WRITE, 8'hFF, 1'b0);
        run_cmd(CMD_WRITE, 8'h96, 1'b0);
        run_cmd(CMD_READ_BYTE, 8'h00, 1'b0);
        run_cmd(CMD_READ_BIT, 8'h00, 1'b0);
        line_mode = LINE_LOW;
        run_cmd(CMD_RESET, 8'h00, 1'b0);
        line_mode = LINE_HIGH;
        run_cmd(CMD_RESET, 8'h00, 1'b0);
        line_mode = LINE_RANDOM;
    endtask

    task automatic test_busy_requests();
        load_timing(16'd2, 16'd3, 8'd2, 16'd2, 16'd3, 16'd1, 16'd2);
        run_cmd(CMD_RESET, 8'h00, 1'b1);
        run_cmd(CMD_WRITE, 8'h5A, 1'b1);
        run_cmd(CMD_READ_BYTE, 8'h00, 1'b1);
        run_cmd(CMD_READ_BIT, 8'h00, 1'b1);
    endtask

    task automatic test_bad_index();
        quiesce();
        write_reg(REG_UNUSED, 16'h0000);
        close_config();
        run_cmd(CMD_WRITE, 8'hF0, 1'b0);
        run_cmd(CMD_RESET, 8'h00, 1'b0);
    endtask

    // full-scale short low pulse, sent with no idling
    task automatic test_max_durations();
        calm = 1'b1;
        load_timing(16'd1, 16'd1, 8'hFF, 16'd0, 16'd0, 16'd0, 16'd0);
        run_cmd(CMD_WRITE, 8'h01, 1'b0);
        calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        int   set_idx;
        int   set_end;
        int   pick;
        logic [7:0] wdata;
        for (set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
            load_timing(16'($urandom_range(6)), 16'($urandom_range(6, 1)),
                        8'($urandom_range(3, 1)), 16'($urandom_range(5)),
                        16'($urandom_range(5)), 16'($urandom_range(4)),
                        16'($urandom_range(5)));
            calm    = (set_idx == 2);
            set_end = ticks_sent + TICKS_PER_SET;
            while (ticks_sent < set_end) begin
                pick      = $urandom_range(99);
                line_mode = ($urandom_range(3) == 0) ? LINE_HIGH : LINE_RANDOM;
                case ($urandom_range(7))
                    0:       wdata = 8'h00;
                    1:       wdata = 8'hFF;
                    default: wdata = 8'($urandom);
                endcase
                if (pick < 10)
                    send_tick(1'b0, cmd_t'($urandom_range(3)), wdata);
                else
                    run_cmd(cmd_t'($urandom_range(3)), wdata, $urandom_range(4) == 0);
            end
        end
        calm      = 1'b0;
        line_mode = LINE_RANDOM;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_timing();
        test_presence();
        test_zero_durations();
        test_busy_requests();
        test_bad_index();
        test_max_durations();
        test_random_traffic();
        quiesce();
        if (status_q.size() != 0) begin
            mismatch_cnt++;
            $display("%0t: %0d results never arrived", $time, status_q.size());
        end
        $display("covered %0d ticks and %0d checked results: %0d resets, %0d writes,",
                 ticks_sent, results_seen, cmds_started[CMD_RESET], cmds_started[CMD_WRITE]);
        $display("  %0d byte reads, %0d bit reads; timing sets: defaults, minimum,",
                 cmds_started[CMD_READ_BYTE], cmds_started[CMD_READ_BIT]);
        $display("  full-scale short pulse, busy requests and %0d random sets", RANDOM_SETS);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
